>>> sv/bhcs_pkg.sv
// Shared constants, command and register codes, and the bin entry layout
// for the binned histogram core. Depends on nothing else.
`default_nettype none

package bhcs_pkg;

   // Store geometry.
   localparam int NUM_BINS  = 256;
   localparam int BIN_W     = $clog2(NUM_BINS);

   // Field widths fixed by the interface.
   localparam int CMD_W     = 2;
   localparam int SAMPLE_W  = 32;
   localparam int IDX_W     = 8;
   localparam int CNT_W     = 32;
   localparam int SUM_W     = 56;
   localparam int MIN_W     = 32;
   localparam int STEP_W    = 31;
   localparam int SCALE_W   = 24;
   localparam int BINS_W    = 9;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = 32;

   // Datapath widths.
   localparam int FRAC_W    = 16;
   localparam int PROD_W    = SAMPLE_W + SCALE_W;
   localparam int DIFF_W    = PROD_W + 1;
   localparam int REM_W     = DIFF_W - FRAC_W;
   localparam int ITER_W    = $clog2(BIN_W + 1);

   // Reset values of the configuration registers.
   localparam logic signed [MIN_W-1:0]   BIN_MIN_RST = '0;
   localparam logic [STEP_W-1:0]         BIN_STEP_RST = STEP_W'(131072);
   localparam logic signed [SCALE_W-1:0] SCALE_RST = SCALE_W'(65536);
   localparam logic [BINS_W-1:0]         BINS_RST = BINS_W'(10);

   // Saturation limits.
   localparam logic [CNT_W-1:0]        COUNT_MAX = {CNT_W{1'b1}};
   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD   = 2'd0,
      CMD_READ  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BIN_MIN  = 2'd0,
      CSR_BIN_STEP = 2'd1,
      CSR_SCALE    = 2'd2,
      CSR_BINS     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                    sat;
      logic [CNT_W-1:0]        count;
      logic signed [SUM_W-1:0] sum;
   } bin_entry_type;

endpackage

`default_nettype wire

>>> sv/binned_histogram_count_sum_core.sv
// Top level of the binned histogram: command decode, scaling multiplier,
// bin divider and the read-modify-write of the bin store. Uses bhcs_pkg.
`default_nettype none

// Equal-width bin histogram with a count and a sum per bin. A transaction is
// taken when start is high and busy is low, and each transaction produces
// exactly one result, shown for a single cycle with rsp_valid high; the
// receiver cannot hold results off, so it must take every strobe. An add
// that hits keeps busy high through the scaling multiply, the offset
// subtract, the restoring divider, which settles one bin number bit per
// cycle plus a first out-of-range test, the bin store's registered read
// and the update and write-back. Its result appears in the following
// cycle, in which a new transaction may already be taken. An add that
// misses ends sooner: after the offset subtract when the scaled sample
// lies below the first bin or the step is zero, and at the store read
// when the bin number lies beyond the active bins. A read keeps busy
// high through the store read and then the result. A clear and the
// unused command leave busy low and answer in the next cycle, so they
// may be issued on every cycle. Each bin has a valid flag held in
// flip-flops; reset and a clear drop all flags at once and a bin whose
// flag is low reads as zero, so there is no clearing pass after reset.
// Configuration writes must only be made while the block is idle and no
// result is outstanding.
module binned_histogram_count_sum_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [bhcs_pkg::CMD_W-1:0]             req_cmd,
   input  logic signed [bhcs_pkg::SAMPLE_W-1:0]   req_sample,
   input  logic [bhcs_pkg::IDX_W-1:0]             req_read_index,
   input  logic                                   csr_we,
   input  logic [bhcs_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [bhcs_pkg::CSR_W-1:0]             csr_wdata,
   output logic                                   rsp_valid,
   output logic                                   rsp_hit,
   output logic [bhcs_pkg::IDX_W-1:0]             rsp_bin_index,
   output logic [bhcs_pkg::CNT_W-1:0]             rsp_bin_count,
   output logic signed [bhcs_pkg::SUM_W-1:0]      rsp_bin_sum,
   output logic                                   rsp_saturated
);
   import bhcs_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_MUL    = 6'b000010,
      S_OFFSET = 6'b000100,
      S_DIV    = 6'b001000,
      S_FETCH  = 6'b010000,
      S_UPDATE = 6'b100000
   } state_type;

   // Control state.
   state_type                  state_ff, state_in;
   logic [NUM_BINS-1:0]        valid_ff, valid_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   // Configuration registers.
   logic signed [MIN_W-1:0]    bin_min_ff, bin_min_in;
   logic [STEP_W-1:0]          bin_step_ff, bin_step_in;
   logic signed [SCALE_W-1:0]  scale_ff, scale_in;
   logic [BINS_W-1:0]          bins_ff, bins_in;

   // Working registers of the transaction in flight.
   cmd_type                    cmd_ff, cmd_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [BIN_W-1:0]           addr_ff, addr_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic [REM_W-1:0]           rem_ff, rem_in;
   logic [REM_W-1:0]           div_ff, div_in;
   logic                       ovf_ff, ovf_in;
   logic [ITER_W-1:0]          iter_ff, iter_in;
   logic                       rd_valid_ff, rd_valid_in;
   bin_entry_type              rd_entry_ff;

   // Result registers.
   logic                       rsp_hit_ff, rsp_hit_in;
   logic [IDX_W-1:0]           rsp_index_ff, rsp_index_in;
   logic [CNT_W-1:0]           rsp_count_ff, rsp_count_in;
   logic signed [SUM_W-1:0]    rsp_sum_ff, rsp_sum_in;
   logic                       rsp_sat_ff, rsp_sat_in;

   // Bin store: one entry per bin, registered read.
   bin_entry_type              mem [NUM_BINS];
   logic                       mem_we;
   bin_entry_type              mem_wdata;

   // Datapath nets.
   logic signed [DIFF_W-1:0]   diff;
   logic                       div_ge;
   logic [BINS_W-1:0]          bin_limit;
   logic                       add_hit;
   bin_entry_type              cur_entry;
   logic                       count_full;
   logic signed [SUM_W:0]      sum_wide;
   logic                       sum_over;
   logic                       sum_under;
   bin_entry_type              new_entry;

   assign busy          = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit       = rsp_hit_ff;
   assign rsp_bin_index = rsp_index_ff;
   assign rsp_bin_count = rsp_count_ff;
   assign rsp_bin_sum   = rsp_sum_ff;
   assign rsp_saturated = rsp_sat_ff;

   // Scaled sample less the lower edge, both in Q.16. The product is at most
   // 2^54 in magnitude and the edge at most 2^47, so one guard bit suffices.
   assign diff = $signed({prod_ff[PROD_W-1], prod_ff})
               - $signed({{(DIFF_W-MIN_W-FRAC_W){bin_min_ff[MIN_W-1]}},
                          bin_min_ff, {FRAC_W{1'b0}}});

   // The divisor carries sixteen zero fraction bits, so the bin number is
   // the integer part of the offset divided by the step; the divider works
   // on the offset with its fraction dropped.
   assign div_ge = (rem_ff >= div_ff);

   // A configured bin count beyond the store acts as the store size.
   assign bin_limit = (bins_ff > BINS_W'(NUM_BINS)) ? BINS_W'(NUM_BINS) : bins_ff;
   assign add_hit   = !ovf_ff && (BINS_W'(addr_ff) < bin_limit);

   // An entry whose valid flag is low has not been written since the last
   // clear and reads as zero.
   assign cur_entry  = rd_valid_ff ? rd_entry_ff : '0;
   assign count_full = (cur_entry.count == COUNT_MAX);
   assign sum_wide   = $signed({cur_entry.sum[SUM_W-1], cur_entry.sum})
                     + $signed({{(SUM_W+1-SAMPLE_W){sample_ff[SAMPLE_W-1]}},
                                sample_ff});
   assign sum_over   = (sum_wide[SUM_W:SUM_W-1] == 2'b01);
   assign sum_under  = (sum_wide[SUM_W:SUM_W-1] == 2'b10);

   always_comb begin
      new_entry.count = count_full ? cur_entry.count : cur_entry.count + 1'b1;
      if (sum_over) begin
         new_entry.sum = SUM_MAX;
      end else if (sum_under) begin
         new_entry.sum = SUM_MIN;
      end else begin
         new_entry.sum = sum_wide[SUM_W-1:0];
      end
      // The mark is sticky until the next clear.
      new_entry.sat = cur_entry.sat | count_full | sum_over | sum_under;
   end

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      bin_min_in   = bin_min_ff;
      bin_step_in  = bin_step_ff;
      scale_in     = scale_ff;
      bins_in      = bins_ff;
      cmd_in       = cmd_ff;
      sample_in    = sample_ff;
      addr_in      = addr_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      ovf_in       = ovf_ff;
      iter_in      = iter_ff;
      rd_valid_in  = rd_valid_ff;
      mem_we       = 1'b0;
      mem_wdata    = new_entry;
      // A result is all zero unless a branch below says otherwise.
      rsp_valid_in = 1'b0;
      rsp_hit_in   = 1'b0;
      rsp_index_in = '0;
      rsp_count_in = '0;
      rsp_sum_in   = '0;
      rsp_sat_in   = 1'b0;

      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_BIN_MIN:  bin_min_in  = csr_wdata[MIN_W-1:0];
            CSR_BIN_STEP: bin_step_in = csr_wdata[STEP_W-1:0];
            CSR_SCALE:    scale_in    = csr_wdata[SCALE_W-1:0];
            CSR_BINS:     bins_in     = csr_wdata[BINS_W-1:0];
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in    = cmd_type'(req_cmd);
               sample_in = req_sample;
               addr_in   = BIN_W'(req_read_index);
               unique case (cmd_type'(req_cmd))
                  CMD_ADD:  state_in = S_MUL;
                  CMD_READ: state_in = S_FETCH;
                  CMD_CLEAR: begin
                     valid_in     = '0;
                     rsp_valid_in = 1'b1;
                  end
                  CMD_NOP:  rsp_valid_in = 1'b1;
               endcase
            end
         end
         S_MUL: begin
            prod_in  = sample_ff * scale_ff;
            state_in = S_OFFSET;
         end
         S_OFFSET: begin
            if (diff[DIFF_W-1] || (bin_step_ff == '0)) begin
               // Below the first bin, or no usable step: a miss.
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               rem_in   = diff[DIFF_W-1:FRAC_W];
               div_in   = REM_W'(bin_step_ff) << BIN_W;
               iter_in  = ITER_W'(BIN_W);
               addr_in  = '0;
               ovf_in   = 1'b0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // The first step tests against the step times the store size;
            // success there means the bin number does not fit the store.
            if (div_ge) begin
               rem_in = rem_ff - div_ff;
            end
            if (iter_ff == ITER_W'(BIN_W)) begin
               ovf_in = div_ge;
            end else begin
               addr_in = {addr_ff[BIN_W-2:0], div_ge};
            end
            div_in = div_ff >> 1;
            if (iter_ff == '0) begin
               state_in = S_FETCH;
            end else begin
               iter_in = iter_ff - 1'b1;
            end
         end
         S_FETCH: begin
            rd_valid_in = valid_ff[addr_ff];
            if ((cmd_ff == CMD_ADD) && !add_hit) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            rsp_valid_in = 1'b1;
            rsp_index_in = IDX_W'(addr_ff);
            state_in     = S_IDLE;
            if (cmd_ff == CMD_ADD) begin
               mem_we            = 1'b1;
               valid_in[addr_ff] = 1'b1;
               rsp_hit_in        = 1'b1;
               rsp_count_in      = new_entry.count;
               rsp_sum_in        = new_entry.sum;
               rsp_sat_in        = new_entry.sat;
            end else begin
               rsp_count_in = cur_entry.count;
               rsp_sum_in   = cur_entry.sum;
               rsp_sat_in   = cur_entry.sat;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         bin_min_ff   <= BIN_MIN_RST;
         bin_step_ff  <= BIN_STEP_RST;
         scale_ff     <= SCALE_RST;
         bins_ff      <= BINS_RST;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         bin_min_ff   <= bin_min_in;
         bin_step_ff  <= bin_step_in;
         scale_ff     <= scale_in;
         bins_ff      <= bins_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      sample_ff    <= sample_in;
      addr_ff      <= addr_in;
      prod_ff      <= prod_in;
      rem_ff       <= rem_in;
      div_ff       <= div_in;
      ovf_ff       <= ovf_in;
      iter_ff      <= iter_in;
      rd_valid_ff  <= rd_valid_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_index_ff <= rsp_index_in;
      rsp_count_ff <= rsp_count_in;
      rsp_sum_ff   <= rsp_sum_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   // Bin store. Only one transaction is in flight, so a read and a write of
   // the same entry never overlap.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr_ff] <= mem_wdata;
      end
      if (state_ff == S_FETCH) begin
         rd_entry_ff <= mem[addr_ff];
      end
   end

   // An accepted transaction either starts work or answers at once.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted transaction neither started nor answered");

   // A hit always reports a bin that has counted at least this sample.
   a_hit_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> (rsp_bin_count != '0))
      else $error("hit reported with a zero count");

   // Results are issued only on the way back to idle.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while still busy");

   // A written bin is marked valid.
   a_write_valid: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> valid_ff[$past(addr_ff)])
      else $error("written bin not marked valid");

   // The shifted divisor never runs out while dividing.
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (div_ff != '0))
      else $error("divisor reached zero during division");

endmodule

`default_nettype wire
